[design/iaid_pkg.sv]
package iaid_pkg;

    localparam int DATA_W  = 32;
    localparam int POS_W   = 7;
    localparam int CMD_W   = 2;
    localparam int STAT_W  = 2;

    typedef logic signed [DATA_W-1:0] t_word;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_READ   = 2'd3
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK     = 2'd0,
        ST_BADPOS = 2'd1,
        ST_FULL   = 2'd2
    } t_status;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [POS_W-1:0] position;
        t_word            value;
    } t_in;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [POS_W-1:0]  element_count;
        t_word             read_value;
    } t_out;

    typedef struct packed {
        logic load;
        logic shift_up;
        logic shift_down;
        logic rd_sel;
    } t_cell_ctl;

endpackage

[design/iaid_cell.sv]
module iaid_cell (
    input  logic               i_clk,
    input  iaid_pkg::t_cell_ctl i_ctl,
    input  iaid_pkg::t_word    i_value,
    input  iaid_pkg::t_word    i_left,
    input  iaid_pkg::t_word    i_right,
    input  iaid_pkg::t_word    i_rd_chain,
    output iaid_pkg::t_word    o_data,
    output iaid_pkg::t_word    o_rd_chain
);
    import iaid_pkg::*;

    t_word r_data;
    t_word n_data;

    always_comb begin
        n_data = r_data;
        if (i_ctl.load) begin
            n_data = i_value;
        end else if (i_ctl.shift_up) begin
            n_data = i_left;
        end else if (i_ctl.shift_down) begin
            n_data = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data     = r_data;
    assign o_rd_chain = i_rd_chain | (i_ctl.rd_sel ? r_data : t_word'(0));

endmodule

[design/indexed_array_insert_delete.sv]
// indexed array with insert and delete by shifting
//
// command channel: a transaction is taken on a rising edge where start is
// high and busy is low. i_data carries command, position and value. busy
// stays low, so a new command may be issued on every cycle.
// result channel: o_done is high for exactly one cycle, in the cycle after
// the command was taken, with status, element count and read value on
// o_result. the receiver cannot stall, so each result must be taken then.
// throughput is one command per cycle: every cell of the row loads, shifts
// up or shifts down in the same edge, and a read passes through the or chain
// along the row into the result register.
// reset clears the count and the result strobe; stored words are not
// cleared and only words below the count are ever read back.
// positions above 127 cannot be named, and the element count shows the
// low 7 bits of the count when CAPACITY is above 127.
module indexed_array_insert_delete #(
    parameter int CAPACITY = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  iaid_pkg::t_in  i_data,
    output logic           o_done,
    output iaid_pkg::t_out o_result
);
    import iaid_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = CW + POS_W;

    logic              accept;
    logic [PW-1:0]     pos_ext;
    logic [PW-1:0]     cnt_ext;
    logic              pos_le_cnt;
    logic              pos_lt_cnt;
    logic              full;
    logic              do_ins;
    logic              do_del;
    logic              do_rd;
    logic [CW+POS_W-1:0] cnt_view;

    t_cell_ctl         ctl [CAPACITY];
    t_word             cell_data [CAPACITY];
    t_word             rd_chain [CAPACITY+1];

    logic [CW-1:0]     r_count;
    logic [CW-1:0]     n_count;
    logic              r_done;
    logic [STAT_W-1:0] r_status;
    logic [STAT_W-1:0] n_status;
    t_word             r_read_value;
    t_word             n_read_value;

    assign busy       = 1'b0;
    assign accept     = start && !busy;
    assign pos_ext    = PW'(i_data.position);
    assign cnt_ext    = PW'(r_count);
    assign pos_le_cnt = pos_ext <= cnt_ext;
    assign pos_lt_cnt = pos_ext < cnt_ext;
    assign full       = r_count == CW'(CAPACITY);
    assign do_ins     = accept && (i_data.command == CMD_INSERT) && pos_le_cnt && !full;
    assign do_del     = accept && (i_data.command == CMD_DELETE) && pos_lt_cnt;
    assign do_rd      = (i_data.command == CMD_READ) && pos_lt_cnt;

    assign rd_chain[CAPACITY] = t_word'(0);

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        localparam logic [PW-1:0] IDX = PW'(g);
        t_word left;
        t_word right;

        assign ctl[g].load       = do_ins && (IDX == pos_ext);
        assign ctl[g].shift_up   = do_ins && (IDX > pos_ext);
        assign ctl[g].shift_down = do_del && (IDX >= pos_ext);
        assign ctl[g].rd_sel     = IDX == pos_ext;

        if (g == 0) begin : g_first
            assign left = t_word'(0);
        end else begin : g_mid_l
            assign left = cell_data[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign right = cell_data[g];
        end else begin : g_mid_r
            assign right = cell_data[g+1];
        end

        iaid_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (ctl[g]),
            .i_value    (i_data.value),
            .i_left     (left),
            .i_right    (right),
            .i_rd_chain (rd_chain[g+1]),
            .o_data     (cell_data[g]),
            .o_rd_chain (rd_chain[g])
        );
    end

    always_comb begin
        n_count      = r_count;
        n_status     = ST_OK;
        n_read_value = t_word'(0);
        case (t_cmd'(i_data.command))
            CMD_CLEAR: begin
                n_count = '0;
            end
            CMD_INSERT: begin
                if (!pos_le_cnt) begin
                    n_status = ST_BADPOS;
                end else if (full) begin
                    n_status = ST_FULL;
                end else begin
                    n_count = r_count + CW'(1);
                end
            end
            CMD_DELETE: begin
                if (!pos_lt_cnt) begin
                    n_status = ST_BADPOS;
                end else begin
                    n_count = r_count - CW'(1);
                end
            end
            CMD_READ: begin
                if (!do_rd) begin
                    n_status = ST_BADPOS;
                end else begin
                    n_read_value = rd_chain[0];
                end
            end
            default: begin
                n_status = ST_BADPOS;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= accept;
            if (accept) begin
                r_count <= n_count;
            end
        end
        if (accept) begin
            r_status     <= n_status;
            r_read_value <= n_read_value;
        end
    end

    assign cnt_view                = (CW + POS_W)'(r_count);
    assign o_done                  = r_done;
    assign o_result.status         = r_status;
    assign o_result.element_count  = cnt_view[POS_W-1:0];
    assign o_result.read_value     = r_read_value;

endmodule

[design/iaid_checker.sv]
module iaid_checker #(
    parameter int CAPACITY = 64
) (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           start,
    input logic           busy,
    input iaid_pkg::t_in  i_data,
    input logic           o_done,
    input iaid_pkg::t_out o_result
);
    import iaid_pkg::*;

    a_done_follows_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> o_done)
        else $error("missing result after accepted transaction");

    a_no_spurious_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(start && !busy) |=> !o_done)
        else $error("result without accepted transaction");

    a_clear_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_data.command == CMD_CLEAR) |=>
            (o_result.status == ST_OK && o_result.element_count == '0))
        else $error("clear did not empty the array");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (CAPACITY > 127 || int'(o_result.element_count) <= CAPACITY))
        else $error("element count above capacity");

    a_rd_zero_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.status != ST_OK) |-> o_result.read_value == '0)
        else $error("read value not zero on failed command");

endmodule

bind indexed_array_insert_delete iaid_checker #(.CAPACITY(CAPACITY)) u_iaid_checker (.*);
